// ===== hdl/gpp_pkg.sv =====
package gpp_pkg;

  localparam int GapW    = 10;
  localparam int IdxW    = 10;
  localparam int CtrW    = 12;
  localparam int HgtW    = 16;
  localparam int CrdW    = 22;
  localparam int ProdW   = 40;
  localparam int KW      = 18;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 12;
  localparam int Stages  = 8;

  localparam logic [CfgIdxW-1:0] REG_POINT_GAP  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MID_COLUMN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MID_ROW    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_Y   = 3'd4;

  // Sine and cosine values in signed Q2.16.
  localparam logic signed [KW-1:0] TRIG_Z = 18'sd46341;
  localparam logic signed [KW-1:0] COS_X  = 18'sd50201;
  localparam logic signed [KW-1:0] SIN_X  = 18'sd42129;
  localparam logic signed [KW-1:0] COS_Y  = 18'sd65446;
  localparam logic signed [KW-1:0] SIN_Y  = 18'sd3433;

  typedef logic signed [CrdW-1:0]  crd_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [HgtW-1:0]  hgt_t;

  function automatic prod_t smul(input crd_t a, input logic signed [KW-1:0] k);
    smul = ProdW'(a) * ProdW'(k);
  endfunction

  // Divides by 65536 with truncation toward zero.
  function automatic crd_t trunc_q16(input prod_t s);
    logic signed [23:0] q;
    logic               fix;
    q = signed'(s[ProdW-1:16]);
    fix = s[ProdW-1] && (s[15:0] != 16'd0);
    trunc_q16 = CrdW'(q + 24'(fix));
  endfunction

endpackage

// ===== hdl/grid_point_projection_top.sv =====
// A result passes through eight register stages on its way to the outputs.
// Throughput: one point per cycle while out_stall is low; each stage holds one round
// of multipliers, a truncating add or the centre add; stalls squeeze out bubbles.
// Reset (rst_n low, synchronous) empties the pipeline and sets point_gap to 1
// and the other configuration registers to 0.
module grid_point_projection_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [11:0]              cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [9:0]               in_grid_column,
  input  logic [9:0]               in_grid_row,
  input  gpp_pkg::hgt_t            in_raw_height,
  output logic                     out_valid,
  input  logic                     out_stall,
  output gpp_pkg::crd_t            out_screen_x,
  output gpp_pkg::crd_t            out_screen_y,
  output gpp_pkg::crd_t            out_depth,
  output gpp_pkg::hgt_t            out_height_out
);
  import gpp_pkg::*;

  logic [GapW-1:0] point_gap_r;
  logic [IdxW-1:0] mid_column_r;
  logic [IdxW-1:0] mid_row_r;
  logic [CtrW-1:0] centre_x_r;
  logic [CtrW-1:0] centre_y_r;

  logic [Stages-1:0] v_r;
  logic [Stages-1:0] ld;

  hgt_t h_r [Stages];

  crd_t  x0_r, y0_r, z0_r;
  prod_t pa_r, pb_r;
  crd_t  z0b_r;
  crd_t  x1_r, y1_r, z0c_r;
  prod_t p0_r, p1_r, p2_r, p3_r;
  crd_t  x1b_r;
  crd_t  y2_r, z1_r, x1c_r;
  prod_t q0_r, q1_r, q2_r, q3_r;
  crd_t  y2b_r;
  crd_t  x2_r, z2_r, y2c_r;
  crd_t  sx_r, sy_r, dz_r;

  logic signed [10:0] dcol_nxt, drow_nxt;
  logic signed [18:0] hx_nxt, z0_nxt;

  always_comb begin
    ld[Stages-1] = !v_r[Stages-1] || !out_stall;
    for (int k = Stages - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[0];

  always_comb begin
    dcol_nxt = signed'({1'b0, in_grid_column}) - signed'({1'b0, mid_column_r});
    drow_nxt = signed'({1'b0, in_grid_row}) - signed'({1'b0, mid_row_r});
    hx_nxt = 19'(in_raw_height);
    z0_nxt = (hx_nxt <<< 3) - hx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_gap_r  <= GapW'(1);
      mid_column_r <= '0;
      mid_row_r    <= '0;
      centre_x_r   <= '0;
      centre_y_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_GAP:  point_gap_r  <= cfg_wdata[GapW-1:0];
        REG_MID_COLUMN: mid_column_r <= cfg_wdata[IdxW-1:0];
        REG_MID_ROW:    mid_row_r    <= cfg_wdata[IdxW-1:0];
        REG_CENTRE_X:   centre_x_r   <= cfg_wdata[CtrW-1:0];
        REG_CENTRE_Y:   centre_y_r   <= cfg_wdata[CtrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      x0_r   <= CrdW'(dcol_nxt) * CrdW'(signed'({1'b0, point_gap_r}));
      y0_r   <= CrdW'(drow_nxt) * CrdW'(signed'({1'b0, point_gap_r}));
      z0_r   <= CrdW'(z0_nxt);
      h_r[0] <= in_raw_height;
    end
    if (ld[1]) begin
      pa_r   <= smul(x0_r - y0_r, TRIG_Z);
      pb_r   <= smul(x0_r + y0_r, TRIG_Z);
      z0b_r  <= z0_r;
      h_r[1] <= h_r[0];
    end
    if (ld[2]) begin
      x1_r   <= trunc_q16(pa_r);
      y1_r   <= trunc_q16(pb_r);
      z0c_r  <= z0b_r;
      h_r[2] <= h_r[1];
    end
    if (ld[3]) begin
      p0_r   <= smul(y1_r, COS_X);
      p1_r   <= smul(z0c_r, SIN_X);
      p2_r   <= smul(y1_r, SIN_X);
      p3_r   <= smul(z0c_r, COS_X);
      x1b_r  <= x1_r;
      h_r[3] <= h_r[2];
    end
    if (ld[4]) begin
      y2_r   <= trunc_q16(p0_r - p1_r);
      z1_r   <= trunc_q16(p2_r + p3_r);
      x1c_r  <= x1b_r;
      h_r[4] <= h_r[3];
    end
    if (ld[5]) begin
      q0_r   <= smul(x1c_r, COS_Y);
      q1_r   <= smul(z1_r, SIN_Y);
      q2_r   <= smul(x1c_r, SIN_Y);
      q3_r   <= smul(z1_r, COS_Y);
      y2b_r  <= y2_r;
      h_r[5] <= h_r[4];
    end
    if (ld[6]) begin
      x2_r   <= trunc_q16(q0_r - q1_r);
      z2_r   <= trunc_q16(q2_r + q3_r);
      y2c_r  <= y2b_r;
      h_r[6] <= h_r[5];
    end
    if (ld[7]) begin
      sx_r   <= x2_r + CrdW'(centre_x_r);
      sy_r   <= y2c_r + CrdW'(centre_y_r);
      dz_r   <= z2_r;
      h_r[7] <= h_r[6];
    end
  end

  assign out_valid      = v_r[Stages-1];
  assign out_screen_x   = sx_r;
  assign out_screen_y   = sy_r;
  assign out_depth      = dz_r;
  assign out_height_out = h_r[Stages-1];

`ifndef ASSERT_OFF
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted point did not enter the first stage");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[Stages-2] && ld[Stages-1]) |=> out_valid)
    else $error("point lost between last two stages");

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !ld[2]) |=> (v_r[2] && $stable(x1_r) && $stable(y1_r)))
    else $error("stalled stage changed its contents");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r == {Stages{1'b1}} && out_stall))
    else $error("input stalled while pipeline has room");
`endif

endmodule
